@@ rtl/core/cpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpi_pkg
// Shared types and constants of the cross power integrator.
// ----------------------------------------------------------------------------
package cpi_pkg;

    localparam int SAMPLE_WIDTH = 8;
    localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
    localparam int TERM_WIDTH   = PROD_WIDTH + 1;
    localparam int CH_WIDTH     = 11;
    localparam int CHCFG_WIDTH  = 12;
    localparam int SPEC_WIDTH   = 16;
    localparam int OUT_WIDTH    = 48;
    localparam int CFG_IDX_WIDTH  = 4;
    localparam int CFG_DATA_WIDTH = 16;

    typedef logic [CFG_IDX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t CFG_CHANNELS = 4'd0;
    localparam cfg_index_t CFG_SPECTRA  = 4'd1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] pol0_re;
        logic signed [SAMPLE_WIDTH-1:0] pol0_im;
        logic signed [SAMPLE_WIDTH-1:0] pol1_re;
        logic signed [SAMPLE_WIDTH-1:0] pol1_im;
    } cpi_in_t;

    typedef struct packed {
        logic [CH_WIDTH-1:0]         channel_index;
        logic signed [OUT_WIDTH-1:0] cross_re;
        logic signed [OUT_WIDTH-1:0] cross_im;
        logic                        last_channel;
    } cpi_out_t;

    // Per-request control from the sequencer to the accumulator
    typedef struct packed {
        logic [CH_WIDTH-1:0] ch;
        logic                first;
        logic                emit;
        logic                last_ch;
    } cpi_cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/cpi_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpi_seq
// Configuration registers and the channel / spectrum counters.
// ----------------------------------------------------------------------------
module cpi_seq #(
    parameter int MAX_CHANNELS = 2048
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire cpi_pkg::cfg_index_t  cfg_index,
    input  wire logic [cpi_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  wire logic                 accept,
    output cpi_pkg::cpi_cmd_t         cmd
);
    import cpi_pkg::*;

    localparam int CH_CAP = (MAX_CHANNELS < 4095) ? MAX_CHANNELS : 4095;

    logic [CHCFG_WIDTH-1:0] chan_cfg_reg;
    logic [SPEC_WIDTH-1:0]  spec_cfg_reg;
    logic [CH_WIDTH-1:0]    ch_cnt_reg;
    logic [CH_WIDTH-1:0]    ch_cnt_next;
    logic [SPEC_WIDTH-1:0]  spec_cnt_reg;
    logic [SPEC_WIDTH-1:0]  spec_cnt_next;
    logic [CHCFG_WIDTH-1:0] nch;
    logic [SPEC_WIDTH-1:0]  nsp;

    always_comb
    begin
        priority if (chan_cfg_reg == '0)
            nch = CHCFG_WIDTH'(1);
        else if (32'(chan_cfg_reg) > CH_CAP)
            nch = CHCFG_WIDTH'(CH_CAP);
        else
            nch = chan_cfg_reg;
        nsp = (spec_cfg_reg == '0) ? SPEC_WIDTH'(1) : spec_cfg_reg;

        cmd.ch      = ch_cnt_reg;
        cmd.first   = (spec_cnt_reg == '0);
        cmd.last_ch = ({1'b0, ch_cnt_reg} >= (nch - CHCFG_WIDTH'(1)));
        cmd.emit    = (spec_cnt_reg >= (nsp - SPEC_WIDTH'(1)));

        ch_cnt_next   = ch_cnt_reg;
        spec_cnt_next = spec_cnt_reg;
        if (accept)
        begin
            if (cmd.last_ch)
            begin
                ch_cnt_next   = '0;
                spec_cnt_next = cmd.emit ? '0 : spec_cnt_reg + SPEC_WIDTH'(1);
            end
            else
            begin
                ch_cnt_next = ch_cnt_reg + CH_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg <= CHCFG_WIDTH'(2048);
            spec_cfg_reg <= SPEC_WIDTH'(1);
            ch_cnt_reg   <= '0;
            spec_cnt_reg <= '0;
        end
        else
        begin
            ch_cnt_reg   <= ch_cnt_next;
            spec_cnt_reg <= spec_cnt_next;
            if (cfg_write)
            begin
                if (cfg_index == CFG_CHANNELS)
                    chan_cfg_reg <= cfg_data[CHCFG_WIDTH-1:0];
                else if (cfg_index == CFG_SPECTRA)
                    spec_cfg_reg <= cfg_data[SPEC_WIDTH-1:0];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cpi_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpi_acc
// Per-channel accumulator memories with a read-modify-write stage and
// forwarding of the write that lands on the same edge as a read.
// ----------------------------------------------------------------------------
module cpi_acc #(
    parameter int MAX_CHANNELS = 2048,
    parameter int ACC_WIDTH    = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 advance,
    input  wire cpi_pkg::cpi_in_t     sample,
    input  wire cpi_pkg::cpi_cmd_t    cmd,
    output logic                      s1_valid,
    output logic                      s1_emit,
    output cpi_pkg::cpi_out_t         s1_result
);
    import cpi_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [ACC_WIDTH-1:0] mem_re [MAX_CHANNELS];
    logic [ACC_WIDTH-1:0] mem_im [MAX_CHANNELS];

    logic [AW-1:0]               rd_addr;
    logic signed [PROD_WIDTH-1:0] p_rr, p_ii, p_ri, p_ir;
    logic signed [TERM_WIDTH-1:0] tre, tim;

    logic                         s1_valid_reg;
    cpi_cmd_t                     s1_cmd_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic signed [TERM_WIDTH-1:0] s1_tre_reg, s1_tim_reg;
    logic [ACC_WIDTH-1:0]         rd_re_reg, rd_im_reg;
    logic                         fwd_hit_reg;
    logic [ACC_WIDTH-1:0]         fwd_re_reg, fwd_im_reg;
    logic [ACC_WIDTH-1:0]         base_re, base_im, sum_re, sum_im;

    always_comb
    begin
        if (32'(cmd.ch) < MAX_CHANNELS)
            rd_addr = AW'(cmd.ch);
        else
            rd_addr = AW'(MAX_CHANNELS - 1);

        p_rr = sample.pol0_re * sample.pol1_re;
        p_ii = sample.pol0_im * sample.pol1_im;
        p_ri = sample.pol0_re * sample.pol1_im;
        p_ir = sample.pol0_im * sample.pol1_re;
        tre  = TERM_WIDTH'(p_rr) + TERM_WIDTH'(p_ii);
        tim  = TERM_WIDTH'(p_ri) - TERM_WIDTH'(p_ir);

        // First spectrum overwrites; otherwise take the freshest copy
        priority if (s1_cmd_reg.first)
        begin
            base_re = '0;
            base_im = '0;
        end
        else if (fwd_hit_reg)
        begin
            base_re = fwd_re_reg;
            base_im = fwd_im_reg;
        end
        else
        begin
            base_re = rd_re_reg;
            base_im = rd_im_reg;
        end
        sum_re = base_re + ACC_WIDTH'(s1_tre_reg);
        sum_im = base_im + ACC_WIDTH'(s1_tim_reg);

        s1_valid                = s1_valid_reg;
        s1_emit                 = s1_cmd_reg.emit;
        s1_result.channel_index = s1_cmd_reg.ch;
        s1_result.cross_re      = OUT_WIDTH'(sum_re);
        s1_result.cross_im      = OUT_WIDTH'(sum_im);
        s1_result.last_channel  = s1_cmd_reg.last_ch;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mem_re[s1_addr_reg] <= sum_re;
            mem_im[s1_addr_reg] <= sum_im;
        end
        if (accept)
        begin
            rd_re_reg   <= mem_re[rd_addr];
            rd_im_reg   <= mem_im[rd_addr];
            fwd_hit_reg <= advance && (s1_addr_reg == rd_addr);
            fwd_re_reg  <= sum_re;
            fwd_im_reg  <= sum_im;
            s1_cmd_reg  <= cmd;
            s1_addr_reg <= rd_addr;
            s1_tre_reg  <= tre;
            s1_tim_reg  <= tim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Retire only what is in flight
    assert property (@(posedge clk) disable iff (!rst_n) advance |-> s1_valid_reg)
        else $error("accumulator retired an empty stage");
    // A held request keeps its address for the write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance && !accept |=> $stable(s1_addr_reg) && s1_valid_reg)
        else $error("stalled stage lost its address");
    // A write on the read edge to the same entry must be forwarded
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && advance && s1_addr_reg == rd_addr |=> fwd_hit_reg)
        else $error("missed forward of same-entry write");

endmodule
`default_nettype wire

@@ rtl/core/cross_power_integrator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cross_power_integrator
// Integrates conj(pol0)*pol1 per channel over a set number of spectra.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  sample    sample_valid/sample_ready   cpi_in_t  (pol0/pol1 re, im)
//  result    result_valid/result_ready   cpi_out_t (channel, cross re/im, last)
//  cfg       cfg_valid/cfg_ready         cfg_index, cfg_data
//
//  One sample per cycle unless a stalled result holds s1; results pass s1 and
//  the result register. Each sample is one memory read at accept and one
//  write-back on advance; a same-entry write on the read edge is forwarded.
//  Reset clears counters, sets default config; the sums need no clearing pass.
//  A stalled result register holds the write-back stage, then the input.
// ----------------------------------------------------------------------------
module cross_power_integrator #(
    parameter int MAX_CHANNELS = 2048,
    parameter int ACC_WIDTH    = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                sample_valid,
    output logic                     sample_ready,
    input  wire cpi_pkg::cpi_in_t    sample,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output cpi_pkg::cpi_out_t        result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire cpi_pkg::cfg_index_t cfg_index,
    input  wire logic [cpi_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
    import cpi_pkg::*;

    cpi_cmd_t cmd;
    cpi_out_t s1_result;
    cpi_out_t result_reg;
    logic     result_valid_reg;
    logic     s1_valid, s1_emit;
    logic     accept, advance;

    assign cfg_ready    = 1'b1;
    assign advance      = s1_valid && (!s1_emit || !result_valid_reg || result_ready);
    assign sample_ready = !s1_valid || advance;
    assign accept       = sample_valid && sample_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    cpi_seq #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (cmd)
    );

    cpi_acc #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .sample    (sample),
        .cmd       (cmd),
        .s1_valid  (s1_valid),
        .s1_emit   (s1_emit),
        .s1_result (s1_result)
    );

    always_ff @(posedge clk)
    begin
        if (advance && s1_emit)
            result_reg <= s1_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance && s1_emit)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // Never overwrite a result still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |-> !(advance && s1_emit))
        else $error("pending result overwritten");
    // A taken result with nothing behind it drops valid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_ready && !(advance && s1_emit) |=> !result_valid_reg)
        else $error("result repeated");
    // A stalled stage blocks new samples
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !advance |-> !sample_ready)
        else $error("sample taken over a stalled stage");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cross power integrator. Samples go in as
// requests over valid/ready. Bursty traffic and receiver stalls vary
// throughout the run. A local integrator tracks the per-channel cross power
// sums and the counters, and predicts every emitted sum. Each result is
// compared field by field against the oldest prediction. Register settings
// change only while the block is idle: zero and oversized channel counts,
// zero and maximum spectra, and writes that land mid-integration.
// ----------------------------------------------------------------------------
module tb_top;

    import cpi_pkg::*;

    localparam int          MAX_CHANNELS  = 2048;
    localparam int          RANDOM_ITEMS  = 1040;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          QUIET_LIMIT   = 2000;
    localparam cfg_index_t  CFG_UNUSED    = 4'd15;

    typedef enum logic [1:0] {RX_OPEN, RX_DENSE, RX_SPARSE, RX_BLOCKS} rx_mode_e;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_ready;
    cpi_in_t                   sample       = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    cpi_out_t                  result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    cfg_index_t                cfg_index    = CFG_CHANNELS;
    logic [CFG_DATA_WIDTH-1:0] cfg_data     = '0;

    // Local copy of the integrator state and registers
    logic [CHCFG_WIDTH-1:0]    cfg_channels = 12'd2048;
    logic [SPEC_WIDTH-1:0]     cfg_spectra  = 16'd1;
    logic [CH_WIDTH-1:0]       chan_ctr     = '0;
    logic [SPEC_WIDTH-1:0]     spec_ctr     = '0;
    logic [OUT_WIDTH-1:0]      sum_re [MAX_CHANNELS];
    logic [OUT_WIDTH-1:0]      sum_im [MAX_CHANNELS];
    bit                        sum_written [MAX_CHANNELS];

    cpi_in_t                   sample_queue [$];
    cpi_out_t                  expected_sums [$];
    cpi_out_t                  want;

    int unsigned               burst_left   = 1;
    int unsigned               gap_left     = 0;
    rx_mode_e                  rx_mode      = RX_OPEN;
    int unsigned               mode_left    = 0;
    int unsigned               stall_left   = 0;
    int unsigned               quiet_cycles = 0;

    int unsigned               error_count   = 0;
    int unsigned               samples_in    = 0;
    int unsigned               sums_checked  = 0;
    int unsigned               reg_writes    = 0;
    int unsigned               random_items  = 0;

    cross_power_integrator #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .ACC_WIDTH    (OUT_WIDTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned active_channels(logic [CHCFG_WIDTH-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_CHANNELS)
            return MAX_CHANNELS;
        return 32'(raw);
    endfunction

    function automatic int unsigned active_spectra(logic [SPEC_WIDTH-1:0] raw);
        return (raw == 0) ? 1 : 32'(raw);
    endfunction

    // A write mid-integration must not make the block add to a sum it never set
    function automatic bit sums_defined(int unsigned n_ch);
        if (spec_ctr == 0)
            return 1'b1;
        if (!sum_written[chan_ctr])
            return 1'b0;
        for (int unsigned i = 0; i < n_ch; i++)
        begin
            if (!sum_written[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void integrate_sample(cpi_in_t s);
        longint      r0, i0, r1, i1, term_re, term_im;
        int unsigned n_ch, n_sp;
        bit          last_ch, last_sp;
        cpi_out_t    sum;
        n_ch    = active_channels(cfg_channels);
        n_sp    = active_spectra(cfg_spectra);
        r0      = longint'($signed(s.pol0_re));
        i0      = longint'($signed(s.pol0_im));
        r1      = longint'($signed(s.pol1_re));
        i1      = longint'($signed(s.pol1_im));
        term_re = r0 * r1 + i0 * i1;
        term_im = r0 * i1 - i0 * r1;
        last_ch = (chan_ctr >= n_ch - 1);
        last_sp = (spec_ctr >= n_sp - 1);
        // First spectrum of an integration overwrites the sum
        if (spec_ctr == 0)
        begin
            sum_re[chan_ctr]      = OUT_WIDTH'(term_re);
            sum_im[chan_ctr]      = OUT_WIDTH'(term_im);
            sum_written[chan_ctr] = 1'b1;
        end
        else
        begin
            sum_re[chan_ctr] = sum_re[chan_ctr] + OUT_WIDTH'(term_re);
            sum_im[chan_ctr] = sum_im[chan_ctr] + OUT_WIDTH'(term_im);
        end
        if (last_sp)
        begin
            sum.channel_index = chan_ctr;
            sum.cross_re      = sum_re[chan_ctr];
            sum.cross_im      = sum_im[chan_ctr];
            sum.last_channel  = last_ch;
            expected_sums.push_back(sum);
        end
        if (last_ch)
        begin
            chan_ctr = '0;
            spec_ctr = last_sp ? '0 : spec_ctr + 1'b1;
        end
        else
        begin
            chan_ctr = chan_ctr + 1'b1;
        end
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] pick_part();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
            1: return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic compare_field(string name, longint want_val, longint got_val);
        if (want_val != got_val)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_val,
                     got_val);
            error_count++;
        end
    endtask

    task automatic push_sample(int r0, int i0, int r1, int i1);
        cpi_in_t s;
        s.pol0_re = SAMPLE_WIDTH'(r0);
        s.pol0_im = SAMPLE_WIDTH'(i0);
        s.pol1_re = SAMPLE_WIDTH'(r1);
        s.pol1_im = SAMPLE_WIDTH'(i1);
        sample_queue.push_back(s);
    endtask

    task automatic push_random(int unsigned count);
        cpi_in_t s;
        repeat (count)
        begin
            s.pol0_re = pick_part();
            s.pol0_im = pick_part();
            s.pol1_re = pick_part();
            s.pol1_im = pick_part();
            sample_queue.push_back(s);
        end
    endtask

    // Hold until every request is accepted and every predicted sum has arrived
    task automatic wait_drained(int unsigned settle);
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || sample_valid || expected_sums.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
        wait_drained(SETTLE_CYCLES);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CHANNELS: cfg_channels = data[CHCFG_WIDTH-1:0];
            CFG_SPECTRA:  cfg_spectra  = data[SPEC_WIDTH-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                integrate_sample(sample);
                samples_in++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left     <= gap_left - 1;
                    sample_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    sample       <= sample_queue.pop_front();
                    sample_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                                  : $urandom_range(1, 24);
                        gap_left   <= $urandom_range(0, 10);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted sum, then stall on a mode that drifts over time
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected result for channel %0d, cross_re %0d",
                             $time, result.channel_index, $signed(result.cross_re));
                    error_count++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    compare_field("channel_index", longint'(want.channel_index),
                                  longint'(result.channel_index));
                    compare_field("cross_re", longint'($signed(want.cross_re)),
                                  longint'($signed(result.cross_re)));
                    compare_field("cross_im", longint'($signed(want.cross_im)),
                                  longint'($signed(result.cross_im)));
                    compare_field("last_channel", longint'(want.last_channel),
                                  longint'(result.last_channel));
                    sums_checked++;
                end
            end
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_e'($urandom_range(0, 3));
                mode_left <= $urandom_range(64, 400);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   result_ready <= 1'b1;
                RX_DENSE:  result_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left   <= stall_left - 1;
                        result_ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left   <= $urandom_range(5, 30);
                        result_ready <= 1'b0;
                    end
                    else
                    begin
                        result_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles, %0d sums still expected", $time,
                 quiet_cycles, expected_sums.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [CHCFG_WIDTH-1:0] new_ch;
        logic [SPEC_WIDTH-1:0]  new_sp;
        int unsigned            span;
        int unsigned            count;
        bit                     pause;
        bit                     first_phase;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, oversized and zero settings, writes mid-count
        write_reg(CFG_UNUSED, CFG_DATA_WIDTH'($urandom));
        write_reg(CFG_CHANNELS, 16'hFFFF);
        push_sample(-128, -128, -128, -128);
        push_sample(127, 127, 127, 127);
        push_sample(-128, 127, -128, -128);
        push_sample(0, 0, 127, -128);
        // Channel counter sits past the new count: wrap on the next sample
        write_reg(CFG_CHANNELS, 16'd3);
        push_sample(127, -128, -128, 127);
        push_sample(-1, -1, -1, -1);
        push_sample(1, -1, -1, 1);
        push_sample(-128, 0, 127, 0);
        write_reg(CFG_CHANNELS, 16'd0);
        write_reg(CFG_SPECTRA, 16'd0);
        push_sample(127, -128, 127, -128);
        push_sample(-128, -128, 127, 127);
        write_reg(CFG_CHANNELS, 16'd2);
        write_reg(CFG_SPECTRA, 16'd3);
        push_random(8);
        // Spectrum counter now past the new count: emit on this spectrum
        write_reg(CFG_SPECTRA, 16'd1);
        push_sample(-128, -128, -128, -128);
        push_sample(127, 127, -128, -128);

        // Full channel count, left partway through the spectrum
        write_reg(CFG_CHANNELS, CFG_DATA_WIDTH'(MAX_CHANNELS));
        push_random(200);

        // Longest integration, cut short by a smaller spectrum count
        write_reg(CFG_CHANNELS, 16'd1);
        write_reg(CFG_SPECTRA, 16'hFFFF);
        push_random(40);
        write_reg(CFG_SPECTRA, 16'd2);
        push_random(5);

        first_phase = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    new_ch = CHCFG_WIDTH'($urandom_range(25, 300));
                    new_sp = SPEC_WIDTH'($urandom_range(1, 2));
                end
                1:
                begin
                    new_ch = CHCFG_WIDTH'($urandom_range(0, 4));
                    new_sp = SPEC_WIDTH'($urandom_range(7, 40));
                end
                default:
                begin
                    new_ch = CHCFG_WIDTH'($urandom_range(0, 24));
                    new_sp = SPEC_WIDTH'($urandom_range(0, 6));
                end
            endcase
            // Keep the channel count when growing it would read unset sums
            if (sums_defined(active_channels(new_ch)) && $urandom_range(0, 4) != 0)
                write_reg(CFG_CHANNELS, {4'($urandom), new_ch});
            if ($urandom_range(0, 4) != 0)
                write_reg(CFG_SPECTRA, new_sp);

            span  = active_channels(cfg_channels) * active_spectra(cfg_spectra);
            count = (span > 200) ? span : span * $urandom_range(1, 3);
            // Leave a partial integration behind now and then
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, span);
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            pause = first_phase || ($urandom_range(0, 5) == 0);
            if (pause)
            begin
                push_random(count / 2);
                wait_drained(0);
                push_random(count - count / 2);
            end
            else
            begin
                push_random(count);
            end
            random_items += count;
            first_phase   = 1'b0;
        end

        wait_drained(SETTLE_CYCLES);
        $display("Summary: %0d samples accepted, %0d sums checked, %0d register writes",
                 samples_in, sums_checked, reg_writes);
        $display("Covered 1 to %0d channels, 1 to 65535 spectra, bursty traffic and stalls",
                 MAX_CHANNELS);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/cpi_pkg.sv
rtl/core/cpi_seq.sv
rtl/core/cpi_acc.sv
rtl/core/cross_power_integrator.sv
dv/tb_top.sv
